>>> rtl/core/cva_pkg.sv
// Package for the CORDIC vectoring angle unit: angle type, fixed-point
// constants and the arctangent step table. No dependencies.
package cva_pkg;

   // Angle is in 1/256 degree, two's complement.
   localparam int AngleWidth = 16;

   // Input coordinates are scaled by 2^FracBits before the first step.
   localparam int FracBits = 16;

   // Guard bits above the scaled input for the CORDIC gain (about 1.65 * sqrt 2).
   localparam int GuardBits = 3;

   // Number of entries in the step table, and so the deepest chain supported.
   localparam int TableLen = 15;

   typedef logic signed [AngleWidth-1:0] angle_type;

   // atan(2^-i) in 1/256 degree.
   localparam angle_type AtanTable [0:TableLen-1] = '{
      16'sd11520, 16'sd6801, 16'sd3593, 16'sd1824, 16'sd916,
      16'sd458,   16'sd229,  16'sd115,  16'sd57,   16'sd29,
      16'sd14,    16'sd7,    16'sd4,    16'sd2,    16'sd1
   };

endpackage

>>> rtl/core/cva_cell.sv
// One CORDIC vectoring step: rotate (x, y) toward y = 0 and update the angle.
// Depends on cva_pkg for the angle type and the step table.
module cva_cell #(
   parameter int DataWidth = 35,
   parameter int Shift     = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        up_valid,
   output logic                        up_ready,
   input  logic signed [DataWidth-1:0] up_x,
   input  logic signed [DataWidth-1:0] up_y,
   input  cva_pkg::angle_type          up_angle,
   output logic                        dn_valid,
   input  logic                        dn_ready,
   output logic signed [DataWidth-1:0] dn_x,
   output logic signed [DataWidth-1:0] dn_y,
   output cva_pkg::angle_type          dn_angle
);

   logic                        valid_ff;
   logic                        valid_in;
   logic signed [DataWidth-1:0] x_ff;
   logic signed [DataWidth-1:0] x_in;
   logic signed [DataWidth-1:0] y_ff;
   logic signed [DataWidth-1:0] y_in;
   cva_pkg::angle_type          angle_ff;
   cva_pkg::angle_type          angle_in;
   logic signed [DataWidth-1:0] x_shifted;
   logic signed [DataWidth-1:0] y_shifted;

   // Take a new item when empty or when the current one moves on.
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   assign x_shifted = up_x >>> Shift;
   assign y_shifted = up_y >>> Shift;

   always_comb begin
      if (up_y > 0) begin
         x_in     = up_x + y_shifted;
         y_in     = up_y - x_shifted;
         angle_in = up_angle + cva_pkg::AtanTable[Shift];
      end else begin
         x_in     = up_x - y_shifted;
         y_in     = up_y + x_shifted;
         angle_in = up_angle - cva_pkg::AtanTable[Shift];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload only on a taken item; hold it while stalled.
   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         angle_ff <= angle_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_x     = x_ff;
   assign dn_y     = y_ff;
   assign dn_angle = angle_ff;

endmodule

>>> rtl/core/cordic_vector_angle_unit.sv
// Top level of the CORDIC vectoring angle unit: a chain of cva_cell steps.
// Depends on cva_pkg and cva_cell.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   request | req_valid, req_stall, req_x_in/y_in | in
//   result  | rsp_valid, rsp_stall, rsp_angle     | out
//
// An item accepted on the request channel steps through the cells in order, from
// cell 0 to the last cell; rsp_valid rises once the last cell holds it.
// The chain takes one item per cycle whenever the result side is not stalled.
// Each cell is its own pipeline register, so a stalled result still lets
// upstream cells fill their bubbles; the request side keeps accepting until all
// ITERATIONS cells hold an item, then req_stall follows rsp_stall.
// Reset (synchronous) clears only the valid bits of the cells.
module cordic_vector_angle_unit #(
   parameter int ITERATIONS  = 15,
   parameter int INPUT_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [INPUT_WIDTH-1:0] req_x_in,
   input  logic signed [INPUT_WIDTH-1:0] req_y_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output cva_pkg::angle_type            rsp_angle
);

   // Scaled input plus guard bits; wide enough that no step overflows.
   localparam int ScaledWidth = INPUT_WIDTH + cva_pkg::FracBits;
   localparam int DataWidth   = ScaledWidth + cva_pkg::GuardBits;

   logic signed [ScaledWidth-1:0] x_scaled;
   logic signed [ScaledWidth-1:0] y_scaled;

   logic                        valid_stage [0:ITERATIONS];
   logic                        ready_stage [0:ITERATIONS];
   logic signed [DataWidth-1:0] x_stage     [0:ITERATIONS];
   logic signed [DataWidth-1:0] y_stage     [0:ITERATIONS];
   cva_pkg::angle_type          angle_stage [0:ITERATIONS];

   // Scale by 2^FracBits and sign-extend into the datapath.
   assign x_scaled = {req_x_in, {cva_pkg::FracBits{1'b0}}};
   assign y_scaled = {req_y_in, {cva_pkg::FracBits{1'b0}}};

   assign valid_stage[0] = req_valid;
   assign x_stage[0]     = DataWidth'(x_scaled);
   assign y_stage[0]     = DataWidth'(y_scaled);
   assign angle_stage[0] = '0;
   assign req_stall      = !ready_stage[0];

   // One cell per iteration; cell i shifts by i and uses table entry i.
   for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
      cva_cell #(
         .DataWidth (DataWidth),
         .Shift     (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (valid_stage[i]),
         .up_ready (ready_stage[i]),
         .up_x     (x_stage[i]),
         .up_y     (y_stage[i]),
         .up_angle (angle_stage[i]),
         .dn_valid (valid_stage[i+1]),
         .dn_ready (ready_stage[i+1]),
         .dn_x     (x_stage[i+1]),
         .dn_y     (y_stage[i+1]),
         .dn_angle (angle_stage[i+1])
      );
   end

   // Last cell is the output register; drop x and y, deliver the angle.
   assign ready_stage[ITERATIONS] = !rsp_stall;
   assign rsp_valid = valid_stage[ITERATIONS];
   assign rsp_angle = angle_stage[ITERATIONS];

endmodule
